// File: rtl/fks_pkg.sv
// Package for the facet key heap sorter: sizes, record type, sequencer states
// and the structs that pass between the sorter, its store and the top level.
// No dependencies.
package fks_pkg;

    localparam int MAX_FACETS = 64;
    localparam int ADDR_W     = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1;
    localparam int CNT_W      = $clog2(MAX_FACETS + 1);
    localparam int J_W        = CNT_W + 1;

    localparam int SECTOR_W = 16;
    localparam int PATCH_W  = 24;
    localparam int FACET_W  = 24;
    localparam int REC_W    = SECTOR_W + PATCH_W + FACET_W;

    typedef logic [REC_W-1:0]  t_rec;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [J_W-1:0]    t_jidx;

    typedef enum logic [3:0] {
        S_LOAD,
        S_OUTER,
        S_HOLD,
        S_SWAP,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_FIN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_rec  wdata;
        logic  re;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_mem_req;

    typedef struct packed {
        logic load;
        logic last;
    } t_emit;

endpackage

// File: rtl/fks_if.sv
// Handshake channels of the facet key heap sorter: input records and sorted results.
// Depends on fks_pkg for the field widths.
interface fks_in_if;
    logic                         valid;
    logic                         ready;
    logic [fks_pkg::SECTOR_W-1:0] sector_key;
    logic [fks_pkg::PATCH_W-1:0]  patch_key;
    logic [fks_pkg::FACET_W-1:0]  facet_key;
    logic                         last_facet;

    modport source (output valid, sector_key, patch_key, facet_key, last_facet,
                    input ready);
    modport sink (input valid, sector_key, patch_key, facet_key, last_facet,
                  output ready);
endinterface

interface fks_out_if;
    logic                         valid;
    logic                         ready;
    logic [fks_pkg::SECTOR_W-1:0] out_sector;
    logic [fks_pkg::PATCH_W-1:0]  out_patch;
    logic [fks_pkg::FACET_W-1:0]  out_facet;
    logic                         out_last;

    modport source (output valid, out_sector, out_patch, out_facet, out_last,
                    input ready);
    modport sink (input valid, out_sector, out_patch, out_facet, out_last,
                  output ready);
endinterface

// File: rtl/fks_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module fks_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: rtl/fks_sorter.sv
// Sequencer of the facet key heap sorter: loads records, runs the heapsort
// over the record store and steps through the sorted store for emission.
// Depends on fks_pkg and fks_if; drives the store through a t_mem_req struct.
module fks_sorter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fks_in_if.sink            i_in,
    output fks_pkg::t_mem_req o_mem_req,
    input  fks_pkg::t_rec     i_rd_a,
    input  fks_pkg::t_rec     i_rd_b,
    input  logic              i_out_free,
    output fks_pkg::t_emit    o_emit
);

    fks_pkg::t_state r_state, n_state;
    fks_pkg::t_cnt   r_count, n_count;
    fks_pkg::t_cnt   r_bound, n_bound;
    fks_pkg::t_cnt   r_top, n_top;
    fks_pkg::t_cnt   r_i, n_i;
    fks_pkg::t_jidx  r_j, n_j;
    fks_pkg::t_cnt   r_k, n_k;
    fks_pkg::t_rec   r_hold, n_hold;

    logic            in_acc;
    logic            room;
    fks_pkg::t_cnt   cnt_new;
    fks_pkg::t_cnt   bound_dec;
    logic            j_in_heap;
    logic            take_b;
    fks_pkg::t_rec   pick;
    fks_pkg::t_jidx  jsel;
    logic            sink_hold;
    logic            emit_last;

    assign in_acc    = i_in.valid && i_in.ready;
    assign room      = (r_count < fks_pkg::CNT_W'(fks_pkg::MAX_FACETS));
    assign cnt_new   = room ? (r_count + fks_pkg::CNT_W'(1)) : r_count;
    assign bound_dec = r_bound - fks_pkg::CNT_W'(1);
    assign j_in_heap = (r_j <= {1'b0, r_bound});
    // The right child only exists while it lies inside the heap.
    assign take_b    = (r_j < {1'b0, r_bound}) && (i_rd_a < i_rd_b);
    assign pick      = take_b ? i_rd_b : i_rd_a;
    assign jsel      = r_j + fks_pkg::J_W'(take_b);
    assign sink_hold = (r_hold < pick);
    assign emit_last = ((r_k + fks_pkg::CNT_W'(1)) == r_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            fks_pkg::S_LOAD: begin
                if (in_acc && i_in.last_facet) begin
                    n_state = (cnt_new < fks_pkg::CNT_W'(2)) ? fks_pkg::S_EMIT_RD
                                                             : fks_pkg::S_OUTER;
                end
            end
            fks_pkg::S_OUTER: begin
                n_state = (r_top > fks_pkg::CNT_W'(1)) ? fks_pkg::S_HOLD : fks_pkg::S_SWAP;
            end
            fks_pkg::S_HOLD: n_state = fks_pkg::S_SIFT_RD;
            fks_pkg::S_SWAP: begin
                n_state = (bound_dec == fks_pkg::CNT_W'(1)) ? fks_pkg::S_FIN
                                                            : fks_pkg::S_SIFT_RD;
            end
            fks_pkg::S_SIFT_RD: begin
                n_state = j_in_heap ? fks_pkg::S_SIFT_CMP : fks_pkg::S_OUTER;
            end
            fks_pkg::S_SIFT_CMP: begin
                n_state = sink_hold ? fks_pkg::S_SIFT_RD : fks_pkg::S_OUTER;
            end
            fks_pkg::S_FIN:     n_state = fks_pkg::S_EMIT_RD;
            fks_pkg::S_EMIT_RD: n_state = fks_pkg::S_EMIT_LD;
            fks_pkg::S_EMIT_LD: begin
                if (i_out_free) begin
                    n_state = emit_last ? fks_pkg::S_LOAD : fks_pkg::S_EMIT_RD;
                end
            end
            default: n_state = fks_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_bound   = r_bound;
        n_top     = r_top;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_hold    = r_hold;
        o_mem_req = '0;
        o_emit    = '0;
        i_in.ready = 1'b0;
        case (r_state)
            fks_pkg::S_LOAD: begin
                i_in.ready = 1'b1;
                if (in_acc) begin
                    o_mem_req.we    = room;
                    o_mem_req.waddr = r_count[fks_pkg::ADDR_W-1:0];
                    o_mem_req.wdata = {i_in.sector_key, i_in.patch_key, i_in.facet_key};
                    n_count = cnt_new;
                    if (i_in.last_facet) begin
                        n_k     = '0;
                        n_bound = cnt_new;
                        n_top   = (cnt_new >> 1) + fks_pkg::CNT_W'(1);
                    end
                end
            end
            fks_pkg::S_OUTER: begin
                o_mem_req.re = 1'b1;
                if (r_top > fks_pkg::CNT_W'(1)) begin
                    n_top = r_top - fks_pkg::CNT_W'(1);
                    o_mem_req.raddr_a = fks_pkg::ADDR_W'(r_top - fks_pkg::CNT_W'(2));
                end else begin
                    // Sort-down: fetch the last heap entry and the root together.
                    o_mem_req.raddr_a = fks_pkg::ADDR_W'(bound_dec);
                    o_mem_req.raddr_b = '0;
                end
            end
            fks_pkg::S_HOLD: begin
                n_hold = i_rd_a;
                n_i    = r_top;
                n_j    = {r_top, 1'b0};
            end
            fks_pkg::S_SWAP: begin
                n_hold          = i_rd_a;
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = fks_pkg::ADDR_W'(bound_dec);
                o_mem_req.wdata = i_rd_b;
                n_bound         = bound_dec;
                n_i             = r_top;
                n_j             = {r_top, 1'b0};
            end
            fks_pkg::S_SIFT_RD: begin
                if (j_in_heap) begin
                    o_mem_req.re      = 1'b1;
                    o_mem_req.raddr_a = fks_pkg::ADDR_W'(r_j - fks_pkg::J_W'(1));
                    o_mem_req.raddr_b = fks_pkg::ADDR_W'(r_j);
                end else begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = fks_pkg::ADDR_W'(r_i - fks_pkg::CNT_W'(1));
                    o_mem_req.wdata = r_hold;
                end
            end
            fks_pkg::S_SIFT_CMP: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = fks_pkg::ADDR_W'(r_i - fks_pkg::CNT_W'(1));
                o_mem_req.wdata = sink_hold ? pick : r_hold;
                if (sink_hold) begin
                    n_i = jsel[fks_pkg::CNT_W-1:0];
                    n_j = {jsel[fks_pkg::CNT_W-1:0], 1'b0};
                end
            end
            fks_pkg::S_FIN: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = '0;
                o_mem_req.wdata = r_hold;
                n_k             = '0;
            end
            fks_pkg::S_EMIT_RD: begin
                o_mem_req.re      = 1'b1;
                o_mem_req.raddr_a = r_k[fks_pkg::ADDR_W-1:0];
            end
            fks_pkg::S_EMIT_LD: begin
                if (i_out_free) begin
                    o_emit.load = 1'b1;
                    o_emit.last = emit_last;
                    n_k         = r_k + fks_pkg::CNT_W'(1);
                    if (emit_last) begin
                        n_count = '0;
                        n_bound = '0;
                    end
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fks_pkg::S_LOAD;
            r_count <= '0;
            r_bound <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_bound <= n_bound;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_hold <= n_hold;
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fks_pkg::CNT_W'(fks_pkg::MAX_FACETS))
        else $error("record count exceeds the store depth");

    a_child_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fks_pkg::S_SIFT_CMP) |-> (r_j <= {1'b0, r_bound}))
        else $error("sift compare on a child outside the heap");

    a_swap_at_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fks_pkg::S_SWAP) |-> (r_top == fks_pkg::CNT_W'(1)
                                          && r_bound >= fks_pkg::CNT_W'(2)))
        else $error("sort-down swap outside the root phase");

    a_last_leaves_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last_facet) |=> (r_state != fks_pkg::S_LOAD))
        else $error("last record did not start the sort");
`endif

endmodule

// File: rtl/facet_key_heap_sort.sv
// Facet key heap sorter. Loading: one record per cycle while the sequencer is in its
// load state, result-free. On the last record the heapsort runs in place in a 64 x 64-bit
// RAM: each sift step is a child read, then a compare and write-back. Emission then
// reads each sorted record from the RAM and loads it into the output register once free.
// Synchronous active-low reset clears the sequencer, record count and output valid;
// the store is not cleared.
module facet_key_heap_sort (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fks_in_if.sink    i_in,
    fks_out_if.source o_out
);

    fks_pkg::t_mem_req mem_req;
    fks_pkg::t_emit    emit;
    fks_pkg::t_rec     rd_a;
    fks_pkg::t_rec     rd_b;
    logic              out_free;

    logic              r_out_valid;
    fks_pkg::t_rec     r_out_rec;
    logic              r_out_last;

    assign out_free = !r_out_valid || o_out.ready;

    fks_sorter u_sorter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_mem_req  (mem_req),
        .i_rd_a     (rd_a),
        .i_rd_b     (rd_b),
        .i_out_free (out_free),
        .o_emit     (emit)
    );

    fks_ram #(
        .WIDTH  (fks_pkg::REC_W),
        .DEPTH  (fks_pkg::MAX_FACETS),
        .ADDR_W (fks_pkg::ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem_req.we),
        .i_waddr   (mem_req.waddr),
        .i_wdata   (mem_req.wdata),
        .i_re      (mem_req.re),
        .i_raddr_a (mem_req.raddr_a),
        .i_raddr_b (mem_req.raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Output register: holds one result transaction until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.load) begin
            r_out_rec  <= rd_a;
            r_out_last <= emit.last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_sector = r_out_rec[fks_pkg::REC_W-1 -: fks_pkg::SECTOR_W];
    assign o_out.out_patch  = r_out_rec[fks_pkg::FACET_W +: fks_pkg::PATCH_W];
    assign o_out.out_facet  = r_out_rec[fks_pkg::FACET_W-1:0];
    assign o_out.out_last   = r_out_last;

endmodule

// File: tb/tb_facet_key_heap_sort.sv
// Self-checking bench for facet_key_heap_sort: loads sets of facet records and checks
// each sorted run against a queue of predicted results, under random idling on both sides.
// Depends on fks_pkg, fks_in_if and fks_out_if from the RTL.
module tb_facet_key_heap_sort;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 40;
    localparam int QUIET_ITEMS    = 40;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_ITEMS   = 62;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic [fks_pkg::SECTOR_W-1:0] sector;
        logic [fks_pkg::PATCH_W-1:0]  patch;
        logic [fks_pkg::FACET_W-1:0]  facet;
        logic                         last;
    } t_facet_rec;

    logic i_clk;
    logic i_rst_n;

    fks_in_if  in_ch ();
    fks_out_if out_ch ();

    facet_key_heap_sort i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_facet_rec    pending_facets[$];
    t_facet_rec    sorted_due[$];
    fks_pkg::t_rec held_keys[$];
    t_facet_rec    prev_rec;

    int total_items;
    int accepted_items;
    int results_seen;
    int fault_count;
    int send_gap;
    int recv_gap;
    int hold_left;
    bit hold_done;
    int idle_cycles;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Sorts the held keys in ascending order and queues one result per key.
    function automatic void release_sorted();
        fks_pkg::t_rec ordered [fks_pkg::MAX_FACETS];
        fks_pkg::t_rec key;
        t_facet_rec    res;
        int            n;
        int            pos;
        n = 0;
        foreach (held_keys[i]) begin
            key = held_keys[i];
            pos = n;
            while (pos > 0 && ordered[pos-1] > key) begin
                ordered[pos] = ordered[pos-1];
                pos--;
            end
            ordered[pos] = key;
            n++;
        end
        for (int k = 0; k < n; k++) begin
            {res.sector, res.patch, res.facet} = ordered[k];
            res.last = (k == n - 1);
            sorted_due.push_back(res);
        end
        held_keys.delete();
    endfunction

    // A record beyond the store size is dropped, but a last flag still closes the set.
    function automatic void absorb_facet(input t_facet_rec rec);
        if (held_keys.size() < fks_pkg::MAX_FACETS)
            held_keys.push_back({rec.sector, rec.patch, rec.facet});
        if (rec.last)
            release_sorted();
    endfunction

    function automatic void push_fixed(input logic [fks_pkg::SECTOR_W-1:0] sector,
                                       input logic [fks_pkg::PATCH_W-1:0] patch,
                                       input logic [fks_pkg::FACET_W-1:0] facet,
                                       input logic last);
        t_facet_rec rec;
        rec.sector = sector;
        rec.patch  = patch;
        rec.facet  = facet;
        rec.last   = last;
        pending_facets.push_back(rec);
    endfunction

    // Keys are often drawn from a narrow range so that ties in the upper fields
    // push the ordering down to the lower ones; now and then a record repeats.
    function automatic void queue_random_set(input int set_len);
        t_facet_rec  rec;
        logic [31:0] ra;
        logic [31:0] rb;
        logic [31:0] rc;
        for (int k = 0; k < set_len; k++) begin
            ra = $urandom;
            rb = $urandom;
            rc = $urandom;
            if (k > 0 && $urandom_range(0, 7) == 0) begin
                rec = prev_rec;
            end else begin
                rec.sector = '0;
                rec.patch  = '0;
                rec.facet  = '0;
                if ($urandom_range(0, 1) == 0)
                    rec.sector[1:0] = ra[1:0];
                else
                    rec.sector = ra[fks_pkg::SECTOR_W-1:0];
                if ($urandom_range(0, 1) == 0)
                    rec.patch[1:0] = rb[1:0];
                else
                    rec.patch = rb[fks_pkg::PATCH_W-1:0];
                if ($urandom_range(0, 3) == 0)
                    rec.facet[1:0] = rc[1:0];
                else
                    rec.facet = rc[fks_pkg::FACET_W-1:0];
            end
            rec.last = (k == set_len - 1);
            prev_rec = rec;
            pending_facets.push_back(rec);
        end
    endfunction

    always @(posedge i_clk) begin : record_driver
        t_facet_rec nxt;
        t_facet_rec sent;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                sent.sector = in_ch.sector_key;
                sent.patch  = in_ch.patch_key;
                sent.facet  = in_ch.facet_key;
                sent.last   = in_ch.last_facet;
                absorb_facet(sent);
                accepted_items <= accepted_items + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap    <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_facets.size() > QUIET_ITEMS &&
                             $urandom_range(0, 7) == 0) begin
                    send_gap    <= $urandom_range(0, 16);
                    in_ch.valid <= 1'b0;
                end else if (pending_facets.size() != 0) begin
                    nxt = pending_facets.pop_front();
                    in_ch.sector_key <= nxt.sector;
                    in_ch.patch_key  <= nxt.patch;
                    in_ch.facet_key  <= nxt.facet;
                    in_ch.last_facet <= nxt.last;
                    in_ch.valid      <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off on the result side while the sender keeps offering records.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_facet_rec got;
        t_facet_rec want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap     <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.sector = out_ch.out_sector;
                got.patch  = out_ch.out_patch;
                got.facet  = out_ch.out_facet;
                got.last   = out_ch.out_last;
                results_seen <= results_seen + 1;
                if (sorted_due.size() == 0) begin
                    if (fault_count < REPORT_MAX)
                        $display("Unexpected result: sector %h patch %h facet %h last %b",
                                 got.sector, got.patch, got.facet, got.last);
                    fault_count++;
                end else begin
                    want = sorted_due.pop_front();
                    if (got.sector !== want.sector || got.patch !== want.patch ||
                        got.facet !== want.facet || got.last !== want.last) begin
                        if (fault_count < REPORT_MAX)
                            $display({"Mismatch: expected %h/%h/%h last %b, ",
                                      "got %h/%h/%h last %b"},
                                     want.sector, want.patch, want.facet, want.last,
                                     got.sector, got.patch, got.facet, got.last);
                        fault_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap     <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (pending_facets.size() > QUIET_ITEMS &&
                         $urandom_range(0, 7) == 0) begin
                recv_gap     <= $urandom_range(0, 16);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // The count restarts on every transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int random_sent;
        int set_len;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.sector_key = '0;
        in_ch.patch_key  = '0;
        in_ch.facet_key  = '0;
        in_ch.last_facet = 1'b0;
        out_ch.ready     = 1'b0;
        accepted_items   = 0;
        results_seen     = 0;
        fault_count      = 0;
        idle_cycles      = 0;
        send_gap         = 0;
        recv_gap         = 0;
        hold_left        = 0;
        hold_done        = 1'b0;

        // Single-record sets at both extremes.
        push_fixed(16'h0000, 24'h000000, 24'h000000, 1'b1);
        push_fixed(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        // Extremes and alternating patterns, mostly in descending order.
        push_fixed(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        push_fixed(16'hFFFF, 24'hFFFFFF, 24'h000000, 1'b0);
        push_fixed(16'hFFFF, 24'h000000, 24'hFFFFFF, 1'b0);
        push_fixed(16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        push_fixed(16'h0000, 24'h000000, 24'h000001, 1'b0);
        push_fixed(16'h0000, 24'h000000, 24'h000000, 1'b0);
        push_fixed(16'h8000, 24'h800000, 24'h800000, 1'b0);
        push_fixed(16'h7FFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        push_fixed(16'h5555, 24'hAAAAAA, 24'h555555, 1'b0);
        push_fixed(16'hAAAA, 24'h555555, 24'hAAAAAA, 1'b1);
        // Equal records, and neighbours that differ only in the lower keys.
        push_fixed(16'h1234, 24'h56789A, 24'hBCDEF0, 1'b0);
        push_fixed(16'h1234, 24'h56789A, 24'hBCDEF0, 1'b0);
        push_fixed(16'h1234, 24'h56789A, 24'hBCDEEF, 1'b0);
        push_fixed(16'h1234, 24'h567899, 24'hBCDEF0, 1'b0);
        push_fixed(16'h1234, 24'h56789A, 24'hBCDEF0, 1'b1);
        // Two records already in order.
        push_fixed(16'h0001, 24'h000002, 24'h000003, 1'b0);
        push_fixed(16'h0002, 24'h000001, 24'h000000, 1'b1);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0)
                set_len = $urandom_range(13, 40);
            else
                set_len = $urandom_range(1, 12);
            queue_random_set(set_len);
            random_sent += set_len;
        end
        // A full store followed by dropped records, the last of them closing the set.
        queue_random_set($urandom_range(fks_pkg::MAX_FACETS + 1, fks_pkg::MAX_FACETS + 3));
        total_items = pending_facets.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_items < total_items)
            @(posedge i_clk);
        while (sorted_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && sorted_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: facet_key_heap_sort.f
rtl/fks_pkg.sv
rtl/fks_if.sv
rtl/fks_ram.sv
rtl/fks_sorter.sv
rtl/facet_key_heap_sort.sv
tb/tb_facet_key_heap_sort.sv
